/* design/lepq_pkg.sv */
// lepq_pkg: shared types, codes and reset constants for the latch edge pattern qualifier
// depends on nothing; imported by every design file and the checker
`timescale 1ns / 1ps
`default_nettype none

package lepq_pkg;

    // fixed field widths
    localparam int MODE_W  = 2;
    localparam int NOW_W   = 32;
    localparam int POS_W   = 16;
    localparam int CFG_W   = 16;
    localparam int INDEX_W = 3;

    // defaults for the top-level parameters
    localparam int TIME_BITS_DEF     = 32;
    localparam int POSITION_BITS_DEF = 16;

    // request modes
    typedef enum logic [MODE_W-1:0] {
        MODE_POLL  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    // configuration register indexes
    localparam logic [INDEX_W-1:0] CFG_BLANKING  = 3'd0;
    localparam logic [INDEX_W-1:0] CFG_PAT_DELAY = 3'd1;
    localparam logic [INDEX_W-1:0] CFG_PRX_DELAY = 3'd2;
    localparam logic [INDEX_W-1:0] CFG_DRAWN     = 3'd3;
    localparam logic [INDEX_W-1:0] CFG_GATE      = 3'd4;

    // configuration reset values
    localparam logic [CFG_W-1:0] BLANKING_RST  = 16'd100;
    localparam logic [CFG_W-1:0] PAT_DELAY_RST = 16'd100;
    localparam logic [CFG_W-1:0] PRX_DELAY_RST = 16'd100;
    localparam logic [CFG_W-1:0] DRAWN_RST     = 16'd0;
    localparam logic [CFG_W-1:0] GATE_RST      = 16'd1024;

    // per-request step controls for the trackers
    typedef struct packed {
        logic poll;
        logic set_cmd;
        logic clear_hist;
    } lepq_ctl_t;

endpackage

`default_nettype wire

/* design/latch_edge_pattern_qualifier_unit.sv */
// latch_edge_pattern_qualifier_unit: top level, input register, config registers, result register
// depends on lepq_pkg, lepq_prox_trk, lepq_latch_trk
`timescale 1ns / 1ps
`default_nettype none

// Takes one request per clock while no poll is stalled. A request is captured in an input
// register and worked by the two trackers against the stored edge state when it issues from
// there. A poll loads its result into the output register as it issues, so a poll result
// passes the input register and then the output register. Set-latch, clear-history and
// unused-mode requests give no result. The only stall is a poll reaching a full output
// register that is not being taken; other requests pass through at one per cycle.
// Configuration writes take effect at the next edge and belong to idle periods.

module latch_edge_pattern_qualifier_unit #(
    parameter int TIME_BITS     = lepq_pkg::TIME_BITS_DEF,
    parameter int POSITION_BITS = lepq_pkg::POSITION_BITS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // configuration write port
    input  wire                               cfg_write,
    input  wire [lepq_pkg::INDEX_W-1:0]       cfg_index,
    input  wire [lepq_pkg::CFG_W-1:0]         cfg_data,
    // request channel
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire [lepq_pkg::MODE_W-1:0]        mode,
    input  wire [lepq_pkg::NOW_W-1:0]         now_ms,
    input  wire                               latch_sensed,
    input  wire                               left_switch_active,
    input  wire                               right_switch_active,
    input  wire signed [lepq_pkg::POS_W-1:0]  winch_position,
    input  wire                               latch_command,
    // result channel
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic                              latched_by_pattern,
    output logic                              latched_by_proximity,
    output logic                              drawn_back,
    output logic                              proximity_raw
);
    import lepq_pkg::*;

    // configuration registers
    logic [CFG_W-1:0] blanking_reg;
    logic [CFG_W-1:0] pat_delay_reg;
    logic [CFG_W-1:0] prx_delay_reg;
    logic [CFG_W-1:0] drawn_reg;
    logic [CFG_W-1:0] gate_reg;

    // input register
    logic              s1_valid_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [NOW_W-1:0]  now_reg;
    logic              sensed_reg;
    logic              prox_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              cmd_reg;

    // command state
    logic commanded_reg, commanded_next;

    logic                             is_poll;
    logic                             issue;
    lepq_ctl_t                        ctl;
    logic [TIME_BITS-1:0]             now_v;
    logic signed [POSITION_BITS-1:0]  pos_v;
    logic signed [POSITION_BITS-1:0]  gate_v;
    logic signed [POSITION_BITS-1:0]  drawn_v;
    logic                             by_prox;
    logic                             by_pattern;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blanking_reg  <= BLANKING_RST;
            pat_delay_reg <= PAT_DELAY_RST;
            prx_delay_reg <= PRX_DELAY_RST;
            drawn_reg     <= DRAWN_RST;
            gate_reg      <= GATE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BLANKING:  blanking_reg  <= cfg_data;
                CFG_PAT_DELAY: pat_delay_reg <= cfg_data;
                CFG_PRX_DELAY: prx_delay_reg <= cfg_data;
                CFG_DRAWN:     drawn_reg     <= cfg_data;
                CFG_GATE:      gate_reg      <= cfg_data;
                default:       ;
            endcase
        end
    end

    // issue control: only a poll waits for the output register
    assign is_poll  = (mode_reg == MODE_POLL);
    assign issue    = s1_valid_reg && (!is_poll || !out_valid || out_ready);
    assign in_ready = !s1_valid_reg || issue;

    always_comb
    begin
        ctl.poll       = issue && (mode_reg == MODE_POLL);
        ctl.set_cmd    = issue && (mode_reg == MODE_SET);
        ctl.clear_hist = issue && (mode_reg == MODE_CLEAR);
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mode_reg   <= mode;
            now_reg    <= now_ms;
            sensed_reg <= latch_sensed;
            prox_reg   <= left_switch_active || right_switch_active;
            pos_reg    <= winch_position;
            cmd_reg    <= latch_command;
        end
    end

    // commanded latch state
    assign commanded_next = ctl.set_cmd ? cmd_reg : commanded_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            commanded_reg <= 1'b1;
        end
        else
        begin
            commanded_reg <= commanded_next;
        end
    end

    // resize time and positions to the working widths
    assign now_v   = TIME_BITS'(now_reg);
    assign pos_v   = POSITION_BITS'(pos_reg);
    assign gate_v  = POSITION_BITS'(gate_reg);
    assign drawn_v = POSITION_BITS'(drawn_reg);

    lepq_prox_trk #(
        .TIME_BITS (TIME_BITS)
    ) u_prox (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .now     (now_v),
        .state   (prox_reg),
        .cmd     (commanded_reg),
        .blank   (blanking_reg),
        .delay   (prx_delay_reg),
        .by_prox (by_prox)
    );

    lepq_latch_trk #(
        .TIME_BITS     (TIME_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_latch (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .now        (now_v),
        .sensed     (sensed_reg),
        .cmd        (cmd_reg),
        .pos        (pos_v),
        .gate       (gate_v),
        .blank      (blanking_reg),
        .delay      (pat_delay_reg),
        .by_pattern (by_pattern)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (ctl.poll)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.poll)
        begin
            latched_by_pattern   <= by_pattern;
            latched_by_proximity <= by_prox;
            drawn_back           <= by_prox || (pos_v <= drawn_v) || by_pattern;
            proximity_raw        <= prox_reg;
        end
    end

endmodule

`default_nettype wire

/* design/lepq_prox_trk.sv */
// lepq_prox_trk: proximity switch tracker, times the rising edge against the command
// depends on lepq_pkg
`timescale 1ns / 1ps
`default_nettype none

module lepq_prox_trk #(
    parameter int TIME_BITS = lepq_pkg::TIME_BITS_DEF
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  lepq_pkg::lepq_ctl_t       ctl,
    input  wire [TIME_BITS-1:0]       now,
    input  wire                       state,
    input  wire                       cmd,
    input  wire [lepq_pkg::CFG_W-1:0] blank,
    input  wire [lepq_pkg::CFG_W-1:0] delay,
    output logic                      by_prox
);
    import lepq_pkg::*;

    localparam int TW1 = TIME_BITS + 1;

    logic                 last_reg, last_next;
    logic                 req_reg, req_next;
    logic [TIME_BITS-1:0] chg_reg, chg_next;
    logic [TIME_BITS-1:0] rise_reg, rise_next;
    logic                 rv_reg, rv_next;
    logic                 in_blank;
    logic                 old_enough;
    logic                 step;

    assign step = ctl.poll || ctl.clear_hist;

    // now still inside the blanking window after the last command change
    assign in_blank = {1'b0, now} < ({1'b0, chg_reg} + TW1'(blank));

    // edge tracking, then command change, then rearm on active switch
    always_comb
    begin
        last_next = last_reg;
        req_next  = req_reg;
        chg_next  = chg_reg;
        rise_next = rise_reg;
        rv_next   = rv_reg;
        if (step)
        begin
            if (last_reg != state)
            begin
                last_next = state;
                if (state)
                begin
                    rise_next = now;
                    rv_next   = 1'b1;
                end
                if (in_blank)
                begin
                    rv_next   = 1'b0;
                    last_next = cmd;
                end
            end
            if (cmd != req_reg)
            begin
                chg_next  = now;
                rv_next   = 1'b0;
                req_next  = cmd;
                last_next = cmd;
            end
            if (state && !rv_next)
            begin
                rise_next = now;
                rv_next   = 1'b1;
            end
        end
    end

    // rise older than the delay, no wrap
    assign old_enough = ({1'b0, rise_next} + TW1'(delay)) < {1'b0, now};
    assign by_prox    = state && rv_next && old_enough;

    // tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= 1'b0;
            req_reg  <= 1'b1;
            chg_reg  <= '0;
            rise_reg <= '0;
            rv_reg   <= 1'b0;
        end
        else
        begin
            last_reg <= last_next;
            req_reg  <= req_next;
            chg_reg  <= chg_next;
            rise_reg <= rise_next;
            rv_reg   <= rv_next;
        end
    end

endmodule

`default_nettype wire

/* design/lepq_latch_trk.sv */
// lepq_latch_trk: latch sensor edge tracker, checks the fall-then-rise pattern
// depends on lepq_pkg
`timescale 1ns / 1ps
`default_nettype none

module lepq_latch_trk #(
    parameter int TIME_BITS     = lepq_pkg::TIME_BITS_DEF,
    parameter int POSITION_BITS = lepq_pkg::POSITION_BITS_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  lepq_pkg::lepq_ctl_t             ctl,
    input  wire        [TIME_BITS-1:0]      now,
    input  wire                             sensed,
    input  wire                             cmd,
    input  wire signed [POSITION_BITS-1:0]  pos,
    input  wire signed [POSITION_BITS-1:0]  gate,
    input  wire        [lepq_pkg::CFG_W-1:0] blank,
    input  wire        [lepq_pkg::CFG_W-1:0] delay,
    output logic                            by_pattern
);
    import lepq_pkg::*;

    localparam int TW1 = TIME_BITS + 1;

    logic                 last_reg, last_next;
    logic                 req_reg, req_next;
    logic [TIME_BITS-1:0] chg_reg, chg_next;
    logic [TIME_BITS-1:0] rise_reg, rise_next;
    logic                 rv_reg, rv_next;
    logic [TIME_BITS-1:0] fall_reg, fall_next;
    logic                 fv_reg, fv_next;
    logic                 in_blank;
    logic                 edge_seen;
    logic                 old_enough;

    assign in_blank  = {1'b0, now} < ({1'b0, chg_reg} + TW1'(blank));
    assign edge_seen = (last_reg != sensed) && (pos < gate);

    // per-mode state update
    always_comb
    begin
        last_next = last_reg;
        req_next  = req_reg;
        chg_next  = chg_reg;
        rise_next = rise_reg;
        rv_next   = rv_reg;
        fall_next = fall_reg;
        fv_next   = fv_reg;
        if (ctl.poll)
        begin
            if (edge_seen)
            begin
                if (sensed)
                begin
                    rise_next = now;
                    rv_next   = 1'b1;
                end
                else
                begin
                    fall_next = now;
                    fv_next   = 1'b1;
                end
                if (in_blank)
                begin
                    rv_next = 1'b0;
                    fv_next = 1'b0;
                end
            end
            last_next = sensed;
        end
        else if (ctl.set_cmd)
        begin
            if (cmd != req_reg)
            begin
                chg_next = now;
                rv_next  = 1'b0;
                fv_next  = 1'b0;
                req_next = cmd;
            end
        end
        else if (ctl.clear_hist)
        begin
            rv_next = 1'b0;
            fv_next = 1'b0;
        end
    end

    // pattern: fall before rise, rise old enough
    assign old_enough = ({1'b0, rise_next} + TW1'(delay)) < {1'b0, now};
    assign by_pattern = sensed && fv_next && rv_next && (fall_next < rise_next) && old_enough;

    // tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= 1'b0;
            req_reg  <= 1'b1;
            chg_reg  <= '0;
            rise_reg <= '0;
            rv_reg   <= 1'b0;
            fall_reg <= '0;
            fv_reg   <= 1'b0;
        end
        else
        begin
            last_reg <= last_next;
            req_reg  <= req_next;
            chg_reg  <= chg_next;
            rise_reg <= rise_next;
            rv_reg   <= rv_next;
            fall_reg <= fall_next;
            fv_reg   <= fv_next;
        end
    end

endmodule

`default_nettype wire

/* design/lepq_checker.sv */
// lepq_checker: port-level assertions for latch_edge_pattern_qualifier_unit
// depends on lepq_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module lepq_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              cfg_write,
    input wire [lepq_pkg::INDEX_W-1:0]      cfg_index,
    input wire [lepq_pkg::CFG_W-1:0]        cfg_data,
    input wire                              in_valid,
    input wire                              in_ready,
    input wire [lepq_pkg::MODE_W-1:0]       mode,
    input wire [lepq_pkg::NOW_W-1:0]        now_ms,
    input wire                              latch_sensed,
    input wire                              left_switch_active,
    input wire                              right_switch_active,
    input wire [lepq_pkg::POS_W-1:0]        winch_position,
    input wire                              latch_command,
    input wire                              out_valid,
    input wire                              out_ready,
    input wire                              latched_by_pattern,
    input wire                              latched_by_proximity,
    input wire                              drawn_back,
    input wire                              proximity_raw
);
    import lepq_pkg::*;

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(latched_by_pattern)
        && $stable(latched_by_proximity) && $stable(drawn_back) && $stable(proximity_raw))
        else $error("result changed while stalled");

    // requests back up only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("request side stalled without a held result");

    // proximity latch needs an active switch
    a_prox_raw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && latched_by_proximity |-> proximity_raw)
        else $error("proximity latch without active switch");

    // either latch indication implies drawn back
    a_drawn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (latched_by_pattern || latched_by_proximity) |-> drawn_back)
        else $error("latched but not drawn back");

endmodule

bind latch_edge_pattern_qualifier_unit lepq_checker u_lepq_checker (.*);

`default_nettype wire
